@@ src/strg_pkg.sv @@
// shared types, constants and the seeding permutation of the subtractive generator
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps
`default_nettype none

package strg_pkg;

    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 8;
    localparam int TABLE_LEN = 54;

    localparam logic [ADDR_W-1:0] TBL_END  = ADDR_W'(TABLE_LEN);
    localparam logic [ADDR_W-1:0] TBL_LAST = ADDR_W'(TABLE_LEN - 1);

    // entries touched by the table update
    localparam logic [ADDR_W-1:0] IDX_HEAD = 6'h00;
    localparam logic [ADDR_W-1:0] IDX_A    = 6'h1F;
    localparam logic [ADDR_W-1:0] IDX_B    = 6'h18;

    localparam logic [ADDR_W-1:0] STIR_A_LAST = 6'h17;   // 24 passes
    localparam logic [ADDR_W-1:0] STIR_B_LAST = 6'h1E;   // 31 passes

    localparam logic [1:0] STIR_ROUNDS = 2'd3;

    localparam logic [DATA_W-1:0] DEFAULT_MOD = 8'd251;

    // request codes
    localparam logic [1:0] REQ_SEED  = 2'd0;
    localparam logic [1:0] REQ_NEXT  = 2'd1;
    localparam logic [1:0] REQ_RANGE = 2'd2;

    // configuration register word indexes
    localparam logic REG_MODULUS = 1'b0;

    localparam logic [ADDR_W-1:0] FILL_ORDER [TABLE_LEN] = '{
        6'h14, 6'h29, 6'h07, 6'h1C, 6'h31, 6'h0F, 6'h24, 6'h02, 6'h17,
        6'h2C, 6'h0A, 6'h1F, 6'h34, 6'h12, 6'h27, 6'h05, 6'h1A, 6'h2F,
        6'h0D, 6'h22, 6'h00, 6'h15, 6'h2A, 6'h08, 6'h1D, 6'h32, 6'h10,
        6'h25, 6'h03, 6'h18, 6'h2D, 6'h0B, 6'h20, 6'h35, 6'h13, 6'h28,
        6'h06, 6'h1B, 6'h30, 6'h0E, 6'h23, 6'h01, 6'h16, 6'h2B, 6'h09,
        6'h1E, 6'h33, 6'h11, 6'h26, 6'h04, 6'h19, 6'h2E, 6'h0C, 6'h21
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_FILL,
        S_ST_A31,
        S_ST_A0,
        S_ST_L0,
        S_ST_P1,
        S_ST_W0,
        S_ST_L24,
        S_ST_P2,
        S_ST_W24,
        S_DRAW,
        S_DRAW_D,
        S_MUL,
        S_RND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [DATA_W-1:0] seed_byte;
        logic [DATA_W-1:0] range_max;
    } t_job;

    typedef struct packed {
        logic              idle;
        logic              done;
        logic [DATA_W-1:0] result;
    } t_seq_stat;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

@@ src/subtractive_table_random_generator_unit.sv @@
// subtractive table random generator, one request in flight: the next input transfer waits
// until the previous result has left the sequencer for the output register; a range
// request adds a multiply and a rounding step to a plain draw
// a draw that runs past entry 53 first runs a table update (24 + 31 passes of the shared
// subtract unit plus reads and writes) and one more pointer check
// seeding reduces the seed by repeated subtraction, fills 54 entries and runs three
// updates; sync active-low reset clears modulus and read pointer, table reads 0
`timescale 1ns / 1ps
`default_nettype none

module subtractive_table_random_generator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_seed_byte,
    input  wire logic [7:0]  i_range_max,

    // output channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_value,

    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [strg_pkg::DATA_W-1:0] r_modulus;
    logic                        r_out_valid;
    logic [strg_pkg::DATA_W-1:0] r_value;

    strg_pkg::t_job      job;
    strg_pkg::t_seq_stat stat;
    logic                in_xfer;
    logic                take;
    logic                cfg_wr;

    // configuration write completes in the access phase; pready is tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= '0;
        end else if (cfg_wr && (paddr[2] == strg_pkg::REG_MODULUS)) begin
            r_modulus <= pwdata[strg_pkg::DATA_W-1:0];
        end
    end

    // readback of the modulus register, zero elsewhere
    always_comb begin
        prdata = '0;
        if (paddr[2] == strg_pkg::REG_MODULUS) begin
            prdata = {24'd0, r_modulus};
        end
    end

    // input transfer starts the sequencer, which is ready only when idle
    assign o_ready       = stat.idle;
    assign in_xfer       = i_valid && o_ready;
    assign job.req_type  = i_req_type;
    assign job.seed_byte = i_seed_byte;
    assign job.range_max = i_range_max;

    strg_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_xfer),
        .i_job     (job),
        .i_ack     (take),
        .i_modulus (r_modulus),
        .o_stat    (stat)
    );

    // output register: a finished result moves in whenever the slot is free or draining,
    // so the sequencer returns to idle while the previous result still waits downstream
    assign take = stat.done && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_value <= stat.result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_value;

    // an accepted request always leaves the idle state
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_ready)
        else $error("sequencer still ready after an input transfer");

    // a handed-over result shows up at the output in the next cycle
    a_take_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (o_valid && (o_value == $past(stat.result))))
        else $error("handed-over result missing at the output");

    // a finished result is held in the sequencer while the output is blocked
    a_done_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.done && !take) |=> (stat.done && $stable(stat.result)))
        else $error("finished result lost while output blocked");

endmodule

`default_nettype wire

@@ src/strg_sub_unit.sv @@
// shared modular subtract unit: (a - b) with one conditional add of the modulus
// depends on strg_pkg for the data width
`timescale 1ns / 1ps
`default_nettype none

module strg_sub_unit (
    input  wire logic [strg_pkg::DATA_W-1:0] i_a,
    input  wire logic [strg_pkg::DATA_W-1:0] i_b,
    input  wire logic [strg_pkg::DATA_W-1:0] i_m,
    output logic      [strg_pkg::DATA_W-1:0] o_diff,
    output logic                             o_borrow
);

    logic [strg_pkg::DATA_W-1:0] raw;

    always_comb begin
        o_borrow = (i_a < i_b);
        raw      = i_a - i_b;
        o_diff   = o_borrow ? (raw + i_m) : raw;
    end

endmodule

`default_nettype wire

@@ src/strg_table_ram.sv @@
// 54 x 8 value table, one write port and one registered read port
// depends on strg_pkg for widths and the request struct
`timescale 1ns / 1ps
`default_nettype none

module strg_table_ram (
    input  wire logic                             i_clk,
    input  wire strg_pkg::t_ram_req               i_req,
    output logic      [strg_pkg::DATA_W-1:0]      o_rdata
);

    logic [strg_pkg::DATA_W-1:0] r_mem [strg_pkg::TABLE_LEN];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

`default_nettype wire

@@ src/strg_seq.sv @@
// sequencer and datapath: seeding, table update, draw and range mapping
// depends on strg_pkg, strg_sub_unit and strg_table_ram
`timescale 1ns / 1ps
`default_nettype none

module strg_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire strg_pkg::t_job              i_job,
    input  wire logic                        i_ack,
    input  wire logic [strg_pkg::DATA_W-1:0] i_modulus,
    output strg_pkg::t_seq_stat              o_stat
);

    strg_pkg::t_state r_state, n_state;
    strg_pkg::t_job   r_job, n_job;

    logic [strg_pkg::ADDR_W-1:0] r_ptr, n_ptr;
    logic [strg_pkg::ADDR_W-1:0] r_cnt, n_cnt;
    logic [1:0]                  r_stirs, n_stirs;
    logic                        r_wrap, n_wrap;
    logic                        r_filled, n_filled;

    logic [strg_pkg::DATA_W-1:0] r_rs, n_rs;
    logic [strg_pkg::DATA_W-1:0] r_e, n_e;
    logic [strg_pkg::DATA_W-1:0] r_acc, n_acc;
    logic [strg_pkg::DATA_W-1:0] r_b, n_b;
    logic [strg_pkg::DATA_W-1:0] r_draw, n_draw;
    logic [strg_pkg::DATA_W-1:0] r_result, n_result;
    logic [2*strg_pkg::DATA_W-1:0] r_prod, n_prod;

    logic [strg_pkg::DATA_W-1:0] eff_m;
    logic [strg_pkg::DATA_W-1:0] sub_a, sub_b, sub_diff;
    logic                        sub_borrow;
    logic [strg_pkg::DATA_W-1:0] ram_rdata, rd;
    logic [strg_pkg::DATA_W-1:0] k_rot;
    logic [strg_pkg::DATA_W:0]   rnd;
    strg_pkg::t_ram_req          ram_req;

    assign eff_m = (i_modulus == '0) ? strg_pkg::DEFAULT_MOD : i_modulus;
    // entries never written since reset read as zero
    assign rd    = r_filled ? ram_rdata : '0;
    assign k_rot = {r_job.range_max[strg_pkg::DATA_W-2:0], r_job.range_max[strg_pkg::DATA_W-1]};
    assign rnd   = {1'b0, r_prod[2*strg_pkg::DATA_W-1:strg_pkg::DATA_W]} + 9'd1;

    strg_sub_unit u_sub (
        .i_a      (sub_a),
        .i_b      (sub_b),
        .i_m      (eff_m),
        .o_diff   (sub_diff),
        .o_borrow (sub_borrow)
    );

    strg_table_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= strg_pkg::S_IDLE;
            r_ptr    <= '0;
            r_cnt    <= '0;
            r_stirs  <= '0;
            r_wrap   <= 1'b0;
            r_filled <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_cnt    <= n_cnt;
            r_stirs  <= n_stirs;
            r_wrap   <= n_wrap;
            r_filled <= n_filled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_rs     <= n_rs;
        r_e      <= n_e;
        r_acc    <= n_acc;
        r_b      <= n_b;
        r_draw   <= n_draw;
        r_result <= n_result;
        r_prod   <= n_prod;
    end

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_ptr    = r_ptr;
        n_cnt    = r_cnt;
        n_stirs  = r_stirs;
        n_wrap   = r_wrap;
        n_filled = r_filled;
        n_rs     = r_rs;
        n_e      = r_e;
        n_acc    = r_acc;
        n_b      = r_b;
        n_draw   = r_draw;
        n_result = r_result;
        n_prod   = r_prod;

        sub_a = r_acc;
        sub_b = r_b;

        ram_req       = '0;
        ram_req.raddr = r_ptr;

        case (r_state)
            strg_pkg::S_IDLE: begin
                if (i_start) begin
                    n_job = i_job;
                    case (i_job.req_type)
                        strg_pkg::REQ_SEED: begin
                            n_rs    = i_job.seed_byte;
                            n_state = strg_pkg::S_MOD;
                        end
                        strg_pkg::REQ_NEXT,
                        strg_pkg::REQ_RANGE: begin
                            n_state = strg_pkg::S_DRAW;
                        end
                        default: begin
                            n_result = '0;
                            n_state  = strg_pkg::S_DONE;
                        end
                    endcase
                end
            end

            // seed reduction by repeated subtraction
            strg_pkg::S_MOD: begin
                sub_a = r_rs;
                sub_b = eff_m;
                if (!sub_borrow) begin
                    n_rs = sub_diff;
                end else begin
                    n_e     = 8'd1;
                    n_cnt   = '0;
                    n_state = strg_pkg::S_FILL;
                end
            end

            strg_pkg::S_FILL: begin
                sub_a         = r_rs;
                sub_b         = r_e;
                ram_req.we    = 1'b1;
                ram_req.waddr = strg_pkg::FILL_ORDER[r_cnt];
                ram_req.wdata = r_e;
                n_e           = sub_diff;
                n_rs          = r_e;
                if (r_cnt == strg_pkg::TBL_LAST) begin
                    n_filled = 1'b1;
                    n_stirs  = strg_pkg::STIR_ROUNDS;
                    n_wrap   = 1'b0;
                    n_state  = strg_pkg::S_ST_A31;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end

            strg_pkg::S_ST_A31: begin
                ram_req.raddr = strg_pkg::IDX_A;
                n_state       = strg_pkg::S_ST_A0;
            end

            strg_pkg::S_ST_A0: begin
                ram_req.raddr = strg_pkg::IDX_HEAD;
                n_b           = rd;
                n_state       = strg_pkg::S_ST_L0;
            end

            strg_pkg::S_ST_L0: begin
                n_acc   = rd;
                n_cnt   = '0;
                n_state = strg_pkg::S_ST_P1;
            end

            strg_pkg::S_ST_P1: begin
                n_acc = sub_diff;
                if (r_cnt == strg_pkg::STIR_A_LAST) begin
                    n_state = strg_pkg::S_ST_W0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end

            strg_pkg::S_ST_W0: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = strg_pkg::IDX_HEAD;
                ram_req.wdata = r_acc;
                ram_req.raddr = strg_pkg::IDX_B;
                n_b           = r_acc;
                n_state       = strg_pkg::S_ST_L24;
            end

            strg_pkg::S_ST_L24: begin
                n_acc   = rd;
                n_cnt   = '0;
                n_state = strg_pkg::S_ST_P2;
            end

            strg_pkg::S_ST_P2: begin
                n_acc = sub_diff;
                if (r_cnt == strg_pkg::STIR_B_LAST) begin
                    n_state = strg_pkg::S_ST_W24;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end

            strg_pkg::S_ST_W24: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = strg_pkg::IDX_B;
                ram_req.wdata = r_acc;
                n_stirs       = r_stirs - 2'd1;
                if (r_stirs == 2'd1) begin
                    n_state = strg_pkg::S_DRAW;
                end else begin
                    n_state = strg_pkg::S_ST_A31;
                end
            end

            // after a wrap entry 0 is read with the pointer left at zero
            strg_pkg::S_DRAW: begin
                if (r_wrap) begin
                    ram_req.raddr = strg_pkg::IDX_HEAD;
                    n_wrap        = 1'b0;
                    n_state       = strg_pkg::S_DRAW_D;
                end else if (r_ptr >= strg_pkg::TBL_END) begin
                    n_ptr   = '0;
                    n_wrap  = 1'b1;
                    n_stirs = 2'd1;
                    n_state = strg_pkg::S_ST_A31;
                end else begin
                    ram_req.raddr = r_ptr;
                    n_ptr         = r_ptr + 6'd1;
                    n_state       = strg_pkg::S_DRAW_D;
                end
            end

            strg_pkg::S_DRAW_D: begin
                if (r_job.req_type == strg_pkg::REQ_RANGE) begin
                    n_draw  = rd;
                    n_state = strg_pkg::S_MUL;
                end else begin
                    n_result = rd;
                    n_state  = strg_pkg::S_DONE;
                end
            end

            strg_pkg::S_MUL: begin
                n_prod  = 16'(r_draw) * 16'(k_rot);
                n_state = strg_pkg::S_RND;
            end

            strg_pkg::S_RND: begin
                n_result = rnd[strg_pkg::DATA_W:1];
                n_state  = strg_pkg::S_DONE;
            end

            strg_pkg::S_DONE: begin
                if (i_ack) begin
                    n_state = strg_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = strg_pkg::S_IDLE;
            end
        endcase
    end

    assign o_stat.idle   = (r_state == strg_pkg::S_IDLE);
    assign o_stat.done   = (r_state == strg_pkg::S_DONE);
    assign o_stat.result = r_result;

endmodule

`default_nettype wire

@@ sim/strg_value_checker.sv @@
`timescale 1ns / 1ps
// value checker for the subtractive table generator: keeps its own copy of the table,
// read pointer and modulus, predicts each value at the request transfer, compares at result
// depends on strg_pkg for the request codes and the modulus register index

module strg_value_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_seed_byte,
    input  logic [7:0]  i_range_max,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_value,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int         TBL_ENTRIES  = 54;
    localparam logic [7:0] MOD_FALLBACK = 8'd251;
    localparam int         HEAD_PASSES  = 24;
    localparam int         TAIL_PASSES  = 31;
    localparam int         HEAD_SRC     = 31;
    localparam int         TAIL_DST     = 24;
    localparam int         SEED_STIRS   = 3;
    localparam logic [2:0] MOD_ADDR     = {strg_pkg::REG_MODULUS, 2'b00};

    // order in which the seed chain is scattered over the table
    localparam logic [5:0] SCATTER [TBL_ENTRIES] = '{
        6'h14, 6'h29, 6'h07, 6'h1C, 6'h31, 6'h0F, 6'h24, 6'h02, 6'h17,
        6'h2C, 6'h0A, 6'h1F, 6'h34, 6'h12, 6'h27, 6'h05, 6'h1A, 6'h2F,
        6'h0D, 6'h22, 6'h00, 6'h15, 6'h2A, 6'h08, 6'h1D, 6'h32, 6'h10,
        6'h25, 6'h03, 6'h18, 6'h2D, 6'h0B, 6'h20, 6'h35, 6'h13, 6'h28,
        6'h06, 6'h1B, 6'h30, 6'h0E, 6'h23, 6'h01, 6'h16, 6'h2B, 6'h09,
        6'h1E, 6'h33, 6'h11, 6'h26, 6'h04, 6'h19, 6'h2E, 6'h0C, 6'h21
    };

    logic [7:0] tbl_mirror [TBL_ENTRIES];
    logic [5:0] rd_ptr;
    logic [7:0] chain_prev;
    logic [7:0] mod_mirror;
    logic [7:0] expected_values [$];
    int         fail_n    = 0;
    int         pending_n = 0;

    assign o_fail_count = fail_n;
    assign o_pending    = pending_n;

    task automatic report_mismatch(input string msg);
        fail_n++;
        $display("%0t ns value check: %s", $time, msg);
    endtask

    function automatic logic [7:0] active_mod();
        return (mod_mirror == 8'd0) ? MOD_FALLBACK : mod_mirror;
    endfunction

    function automatic logic [7:0] mod_sub(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] m);
        logic [7:0] d;
        d = a - b;
        if (a < b) begin
            d = d + m;
        end
        return d;
    endfunction

    function automatic void stir_table();
        logic [7:0] m;
        m = active_mod();
        for (int i = 0; i < HEAD_PASSES; i++)
            tbl_mirror[0] = mod_sub(tbl_mirror[0], tbl_mirror[HEAD_SRC], m);
        for (int i = 0; i < TAIL_PASSES; i++)
            tbl_mirror[TAIL_DST] = mod_sub(tbl_mirror[TAIL_DST], tbl_mirror[0], m);
    endfunction

    // past the end: stir, then entry 0 is read and the pointer parks at 0
    function automatic logic [7:0] draw_byte();
        logic [7:0] v;
        if (rd_ptr >= 6'(TBL_ENTRIES)) begin
            stir_table();
            rd_ptr = 6'd0;
            v      = tbl_mirror[0];
        end else begin
            v      = tbl_mirror[rd_ptr];
            rd_ptr = rd_ptr + 6'd1;
        end
        return v;
    endfunction

    function automatic logic [7:0] reseed_table(input logic [7:0] s);
        logic [7:0] m;
        logic [7:0] e;
        logic [5:0] p;
        m          = active_mod();
        e          = 8'd1;
        chain_prev = s % m;
        for (int i = 0; i < TBL_ENTRIES; i++) begin
            p             = SCATTER[i];
            tbl_mirror[p] = e;
            e             = mod_sub(chain_prev, e, m);
            chain_prev    = tbl_mirror[p];
        end
        repeat (SEED_STIRS) stir_table();
        return draw_byte();
    endfunction

    function automatic logic [7:0] ranged_byte(input logic [7:0] lim);
        logic [7:0]  k;
        logic [15:0] prod;
        logic [8:0]  h;
        k    = {lim[6:0], lim[7]};
        prod = draw_byte() * k;
        h    = {1'b0, prod[15:8]} + 9'd1;
        return h[8:1];
    endfunction

    function automatic logic [7:0] predict_value(input logic [1:0] req, input logic [7:0] sd,
                                                 input logic [7:0] mx);
        case (req)
            strg_pkg::REQ_SEED:  return reseed_table(sd);
            strg_pkg::REQ_NEXT:  return draw_byte();
            strg_pkg::REQ_RANGE: return ranged_byte(mx);
            default:             return 8'd0;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        logic [7:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < TBL_ENTRIES; i++) tbl_mirror[i] = 8'd0;
            rd_ptr     = 6'd0;
            chain_prev = 8'd0;
            mod_mirror = 8'd0;
            expected_values.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == MOD_ADDR) begin
                mod_mirror = i_pwdata[7:0];
            end
            // results first, so a result never matches a request taken in the same cycle
            if (i_out_valid && i_out_ready) begin
                if (expected_values.size() == 0) begin
                    report_mismatch($sformatf("value 0x%02h with no request outstanding",
                                              i_value));
                end else begin
                    want = expected_values.pop_front();
                    if (i_value !== want) begin
                        report_mismatch($sformatf("value 0x%02h, expected 0x%02h",
                                                  i_value, want));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_values.push_back(predict_value(i_req_type, i_seed_byte,
                                                        i_range_max));
            end
        end
        pending_n = expected_values.size();
    end

endmodule

@@ sim/tb_subtractive_table_random_generator_unit.sv @@
`timescale 1ns / 1ps
// top of the subtractive table generator testbench: clock, reset, request and result
// traffic, modulus writes and the verdict; depends on strg_pkg and strg_value_checker

module tb_subtractive_table_random_generator_unit;

    localparam int         CLK_PERIOD       = 4;
    localparam int         PHASES           = 8;
    localparam int         ITEMS_PER_PHASE  = 190;
    localparam int         RANDOM_MOD_PHASE = 6;
    localparam int         HOLD_PHASE       = 2;
    localparam int         PAUSE_PHASE      = 3;
    localparam int         RX_LONG_HOLD     = 400;
    localparam int         DRAIN_LIMIT      = 20000;
    localparam int         TAIL_CYCLES      = 80;
    localparam longint     RUN_LIMIT_NS     = 20_000_000;
    localparam logic [1:0] REQ_UNUSED       = 2'd3;
    localparam logic [2:0] MOD_ADDR         = {strg_pkg::REG_MODULUS, 2'b00};

    // modulus per phase: extremes, one, the default both ways, and a random pick
    localparam logic [7:0] PHASE_MOD [PHASES] = '{
        8'd255, 8'd1, 8'd2, 8'd128, 8'd0, 8'd251, 8'd0, 8'd7
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_req_type;
    logic [7:0]  i_seed_byte;
    logic [7:0]  i_range_max;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int value_mismatches;
    int values_outstanding;

    // stimulus-side controls read by the result sink
    bit rx_long_hold = 1'b0;
    bit no_idle      = 1'b0;

    subtractive_table_random_generator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_seed_byte (i_seed_byte),
        .i_range_max (i_range_max),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    strg_value_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_req_type   (i_req_type),
        .i_seed_byte  (i_seed_byte),
        .i_range_max  (i_range_max),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_value      (o_value),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (value_mismatches),
        .o_pending    (values_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // hard stop in case a transfer never completes
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // result sink: short random stalls, plus one long hold-off on request
    initial begin : result_sink
        i_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (rx_long_hold) begin
                // long hold-off so the block backs up and drops o_ready
                i_ready <= 1'b0;
                repeat (RX_LONG_HOLD) @(posedge i_clk);
                i_ready      <= 1'b1;
                rx_long_hold = 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // called at a rising edge; returns at the edge where the request transfer happens,
    // with valid still high so the next request can follow back to back
    task automatic send_request(input logic [1:0] req, input logic [7:0] sd,
                                input logic [7:0] mx);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_seed_byte <= sd;
        i_range_max <= mx;
        // o_ready is stable at the falling edge; transfer then happens at the next rise
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // sender holds off until every predicted value has been seen
    task automatic wait_drained();
        do @(negedge i_clk); while (values_outstanding != 0);
        @(posedge i_clk);
    endtask

    // setup cycle then access cycle; the write lands at the edge ending the access
    task automatic write_modulus(input logic [7:0] m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MOD_ADDR;
        pwdata  <= {24'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly draws and ranged draws on a seeded table, now and then a reseed or an
    // unused code; range bounds lean a little toward the extremes
    task automatic send_random_item();
        int         pick;
        logic [1:0] req;
        logic [7:0] mx;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            req = strg_pkg::REQ_SEED;
        end else if (pick < 54) begin
            req = strg_pkg::REQ_NEXT;
        end else if (pick < 96) begin
            req = strg_pkg::REQ_RANGE;
        end else begin
            req = REQ_UNUSED;
        end
        if ($urandom_range(0, 9) == 0) begin
            mx = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        end else begin
            mx = 8'($urandom_range(0, 255));
        end
        send_request(req, 8'($urandom_range(0, 255)), mx);
    endtask

    initial begin : stimulus
        logic [7:0] mod_val;
        int         waited;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_req_type  <= strg_pkg::REQ_NEXT;
        i_seed_byte <= 8'd0;
        i_range_max <= 8'd0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= 3'd0;
        pwdata      <= 32'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, default modulus out of reset
        send_request(strg_pkg::REQ_NEXT,  8'h00, 8'h00);   // draw from the all-zero table
        send_request(strg_pkg::REQ_RANGE, 8'hFF, 8'hFF);
        send_request(REQ_UNUSED,          8'hFF, 8'hFF);   // unused code: zero, no state change
        send_request(strg_pkg::REQ_SEED,  8'h00, 8'h00);
        send_request(strg_pkg::REQ_NEXT,  8'hFF, 8'h80);
        send_request(strg_pkg::REQ_RANGE, 8'h00, 8'h00);
        send_request(strg_pkg::REQ_RANGE, 8'h00, 8'hFF);
        send_request(strg_pkg::REQ_RANGE, 8'h00, 8'h80);   // top bit rotates into bit 0
        send_request(strg_pkg::REQ_RANGE, 8'hFF, 8'h7F);
        send_request(strg_pkg::REQ_SEED,  8'hFF, 8'h00);   // reseed, pointer left mid-table
        send_request(strg_pkg::REQ_SEED,  8'hFB, 8'h00);   // seed equal to modulus gives zero
        send_request(REQ_UNUSED,          8'h00, 8'h00);
        send_request(strg_pkg::REQ_NEXT,  8'h5A, 8'hA5);

        // modulus of one: first seeded entry already not below the modulus
        stop_sending();
        wait_drained();
        write_modulus(8'd1);
        send_request(strg_pkg::REQ_SEED,  8'hAB, 8'h55);
        send_request(strg_pkg::REQ_NEXT,  8'h54, 8'hAA);
        send_request(strg_pkg::REQ_RANGE, 8'h00, 8'hFF);

        // random phases, each under its own modulus and opened with a reseed
        for (int ph = 0; ph < PHASES; ph++) begin
            stop_sending();
            wait_drained();
            mod_val = (ph == RANDOM_MOD_PHASE) ? 8'($urandom_range(3, 250)) : PHASE_MOD[ph];
            no_idle = (ph == PHASES - 1);
            write_modulus(mod_val);
            send_request(strg_pkg::REQ_SEED, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == HOLD_PHASE && n == 40) begin
                    rx_long_hold = 1'b1;
                end
                if (ph == PAUSE_PHASE && n == 90) begin
                    stop_sending();
                    wait_drained();
                end
                send_random_item();
            end
        end
        stop_sending();

        // let every predicted value arrive, then watch a while for strays
        waited = 0;
        do begin
            @(negedge i_clk);
            waited++;
        end while (values_outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (values_outstanding != 0) begin
            $display("%0d expected values never arrived", values_outstanding);
        end
        if (value_mismatches == 0 && values_outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/strg_pkg.sv
src/strg_sub_unit.sv
src/strg_table_ram.sv
src/strg_seq.sv
src/subtractive_table_random_generator_unit.sv
sim/strg_value_checker.sv
sim/tb_subtractive_table_random_generator_unit.sv
